// ----- src/mdcf_pkg.sv -----
// ----------------------------------------------------------------------------
// mdcf_pkg
// Shared types and constants for the motor duty command block with failsafe.
// ----------------------------------------------------------------------------
package mdcf_pkg;

	localparam int          NUM_CH      = 4;
	localparam int          HOLD_LEN    = 3;
	localparam int          DUTY_W      = 8;
	localparam int          IDLE_W      = 16;
	localparam logic [7:0]  START_BYTE  = 8'hD1;
	localparam logic [15:0] TIMEOUT_RST = 16'd3;

	typedef enum logic [1:0] {
		REQ_BYTE  = 2'd0,
		REQ_ERROR = 2'd1,
		REQ_TICK  = 2'd2
	} req_type_t;

	typedef logic [NUM_CH-1:0][DUTY_W-1:0] duty_vec_t;

	typedef struct packed {
		logic      applied;
		duty_vec_t duty;
	} frame_evt_t;

endpackage

// ----- src/mdcf_frame_rx.sv -----
// ----------------------------------------------------------------------------
// mdcf_frame_rx
// Frame receiver: hunts for the start byte, collects duty bytes and flags the
// item that completes a frame together with the four new duty values.
// ----------------------------------------------------------------------------
module mdcf_frame_rx (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [1:0]          req,
	input  logic [7:0]          rx_byte,
	output mdcf_pkg::frame_evt_t evt
);
	import mdcf_pkg::*;

	logic             in_frame_q;
	logic [1:0]       count_q;
	logic [7:0]       hold_q [HOLD_LEN];
	logic             last_byte;
	logic             is_byte;
	logic             is_error;

	localparam logic [1:0] LAST_CNT = 2'(HOLD_LEN);

	assign is_byte   = (req == REQ_BYTE);
	assign is_error  = (req == REQ_ERROR);
	assign last_byte = in_frame_q && (count_q == LAST_CNT);

	always_comb begin
		evt.applied = advance && is_byte && last_byte;
		evt.duty[0] = hold_q[0];
		evt.duty[1] = hold_q[1];
		evt.duty[2] = hold_q[2];
		evt.duty[3] = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (advance) begin
			if (is_error) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
			end else if (is_byte) begin
				if (!in_frame_q) begin
					if (rx_byte == START_BYTE) begin
						in_frame_q <= 1'b1;
						count_q    <= '0;
					end
				end else if (last_byte) begin
					in_frame_q <= 1'b0;
					count_q    <= '0;
				end else begin
					count_q <= count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_byte && in_frame_q && !last_byte) begin
			hold_q[count_q] <= rx_byte;
		end
	end

endmodule

// ----- src/motor_duty_command_failsafe.sv -----
// An accepted item passes from the input register into the result registers.
// Throughput: one item per cycle; the input register and the duty/status
// result registers form a two-entry pipeline that stalls only on out_stall.
// Reset (arst_n low): duties zero, failsafe off, idle count zero, timeout 3,
// no frame in progress, no item held.
// ----------------------------------------------------------------------------
// motor_duty_command_failsafe
// Serial duty frames load four motor duties; idle timer periods trigger a
// failsafe ramp-down of every nonzero duty.
// ----------------------------------------------------------------------------
module motor_duty_command_failsafe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  duty_ch1,
	output logic [7:0]  duty_ch2,
	output logic [7:0]  duty_ch3,
	output logic [7:0]  duty_ch4,
	output logic        failsafe_active,
	output logic        frame_applied
);
	import mdcf_pkg::*;

	logic              valid_s1;
	logic [1:0]        req_s1;
	logic [7:0]        byte_s1;
	logic              accept;
	logic              advance;

	logic [15:0]       timeout_q;
	duty_vec_t         duty_q;
	duty_vec_t         duty_d;
	logic              fs_q;
	logic              fs_d;
	logic [IDLE_W-1:0] idle_q;
	logic [IDLE_W-1:0] idle_d;
	logic [IDLE_W-1:0] idle_inc;
	logic              applied_q;
	logic              out_valid_q;
	frame_evt_t        evt;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	mdcf_frame_rx u_frame_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.rx_byte (byte_s1),
		.evt     (evt)
	);

	assign idle_inc = idle_q + 16'd1;

	always_comb begin
		duty_d = duty_q;
		fs_d   = fs_q;
		idle_d = idle_q;
		if (evt.applied) begin
			duty_d = evt.duty;
			fs_d   = 1'b0;
			idle_d = '0;
		end else if (req_s1 == REQ_TICK) begin
			if (idle_inc >= timeout_q) begin
				fs_d   = 1'b1;
				idle_d = '0;
			end else begin
				idle_d = idle_inc;
			end
			if (fs_d) begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (duty_q[i] != '0) begin
						duty_d[i] = duty_q[i] - 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			fs_q        <= 1'b0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				duty_q <= duty_d;
				fs_q   <= fs_d;
				idle_q <= idle_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			applied_q <= evt.applied;
		end
	end

	assign out_valid       = out_valid_q;
	assign duty_ch1        = duty_q[0];
	assign duty_ch2        = duty_q[1];
	assign duty_ch3        = duty_q[2];
	assign duty_ch4        = duty_q[3];
	assign failsafe_active = fs_q;
	assign frame_applied   = applied_q;

`ifndef SYNTHESIS
	a_applied_clears_fs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && applied_q) |-> !fs_q)
		else $error("frame result still shows failsafe");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held item");

	a_fs_rise_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fs_q) |-> (idle_q == '0))
		else $error("failsafe entry left idle count nonzero");
`endif

endmodule
